// ===== rtl/clt_pkg.sv =====
// Shared types, widths and the weight saturation function for the cotangent Laplacian block.
`timescale 1ns / 1ps
`default_nettype none
package clt_pkg;

   localparam int INDEX_BITS  = 14;
   localparam int COORD_BITS  = 32;
   localparam int WEIGHT_BITS = 32;
   localparam int NUM_BITS    = 64;   // signed numerators and their magnitudes
   localparam int ROOT_BITS   = 60;   // floor(sqrt(S)), S below 2^120
   localparam int RAD_BITS    = 120;  // squared cross product length
   localparam int QUOT_BITS   = 33;   // quotient bits kept before the overflow cap
   localparam int DIV_X_BITS  = 80;   // dividend |N| * 2^16 + n
   localparam int DIV_D_BITS  = 61;   // divisor 2n
   localparam int REM_BITS    = 62;   // partial remainder of the divider

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic        [INDEX_BITS-1:0] corner0_index;
      logic signed [COORD_BITS-1:0] corner0_x;
      logic signed [COORD_BITS-1:0] corner0_y;
      logic signed [COORD_BITS-1:0] corner0_z;
      logic        [INDEX_BITS-1:0] corner1_index;
      logic signed [COORD_BITS-1:0] corner1_x;
      logic signed [COORD_BITS-1:0] corner1_y;
      logic signed [COORD_BITS-1:0] corner1_z;
      logic        [INDEX_BITS-1:0] corner2_index;
      logic signed [COORD_BITS-1:0] corner2_x;
      logic signed [COORD_BITS-1:0] corner2_y;
      logic signed [COORD_BITS-1:0] corner2_z;
   } clt_req_type;

   typedef struct packed {
      logic        [INDEX_BITS-1:0]  row_index;
      logic        [INDEX_BITS-1:0]  column_index;
      logic signed [WEIGHT_BITS-1:0] weight;
      logic                          degenerate;
      logic                          last_entry;
   } clt_rsp_type;

   // Round-half-away quotient to saturated Q16.16; zero area saturates by sign.
   function automatic logic [WEIGHT_BITS-1:0] clt_weight(
      input logic [QUOT_BITS-1:0] q,
      input logic                 over,
      input logic                 neg,
      input logic                 nz,
      input logic                 degen
   );
      logic [QUOT_BITS-1:0] qq;
      logic [WEIGHT_BITS-1:0] w;
      qq = q;
      if (degen) begin
         if (!nz) begin
            w = '0;
         end else if (neg) begin
            w = WEIGHT_MIN;
         end else begin
            w = WEIGHT_MAX;
         end
      end else if (!neg) begin
         if (over || q > {1'b0, WEIGHT_MAX}) begin
            w = WEIGHT_MAX;
         end else begin
            w = q[WEIGHT_BITS-1:0];
         end
      end else begin
         if (over || q > {1'b0, WEIGHT_MIN}) begin
            qq = {1'b0, WEIGHT_MIN};
         end
         w = WEIGHT_BITS'(-qq);
      end
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/clt_div_lane.sv =====
// Pipelined restoring divider lane: one quotient bit per stage, overflow flag for large quotients.
`timescale 1ns / 1ps
`default_nettype none
module clt_div_lane import clt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  adv,
   input  wire logic [DIV_X_BITS-1:0] x,
   input  wire logic [DIV_D_BITS-1:0] d,
   output logic      [QUOT_BITS-1:0]  q,
   output logic                       over
);

   logic [REM_BITS-1:0]   rem_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]  quo_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0]  xlo_ff [QUOT_BITS+1];
   logic [DIV_D_BITS-1:0] d_ff   [QUOT_BITS+1];
   logic                  ovr_ff [QUOT_BITS+1];

   // The upper dividend bits start the remainder; if they reach d the quotient is too big.
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= REM_BITS'(x[DIV_X_BITS-1:QUOT_BITS]);
         ovr_ff[0] <= REM_BITS'(x[DIV_X_BITS-1:QUOT_BITS]) >= REM_BITS'(d);
         quo_ff[0] <= '0;
         xlo_ff[0] <= x[QUOT_BITS-1:0];
         d_ff[0]   <= d;
      end
   end

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_step
      logic [REM_BITS:0] rem_in;
      logic [REM_BITS:0] dsr_in;
      logic              ge_in;
      always_comb begin
         rem_in = {rem_ff[j], xlo_ff[j][QUOT_BITS-1-j]};
         dsr_in = (REM_BITS+1)'(d_ff[j]);
         ge_in  = rem_in >= dsr_in;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= ge_in ? REM_BITS'(rem_in - dsr_in) : REM_BITS'(rem_in);
            quo_ff[j+1] <= {quo_ff[j][QUOT_BITS-2:0], ge_in};
            xlo_ff[j+1] <= xlo_ff[j];
            d_ff[j+1]   <= d_ff[j];
            ovr_ff[j+1] <= ovr_ff[j];
         end
      end
   end

   assign q    = quo_ff[QUOT_BITS];
   assign over = ovr_ff[QUOT_BITS];

endmodule
`default_nettype wire

// ===== rtl/cotan_laplacian_triplets.sv =====
// Top level: cotangent Laplacian triplet generator, a deep pipeline with a triplet serializer.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   req_* carries one triangle (three vertex indices, Q16.16 corner positions) with
//   valid/ready; a transfer happens when req_valid and req_ready are both high.
//   rsp_* returns nine triplets per triangle in order: six off-diagonal entries
//   (both orientations per edge), then three diagonal entries; last_entry marks the ninth.
//   The input register is loaded at the transfer edge; ten front stages, a 60-stage
//   square root, a setup stage and 34-stage dividers come before the serializer register,
//   which presents the first triplet of a triangle.
//   Throughput is set by the nine transfers per triangle on the result channel; the
//   pipeline takes a triangle in any cycle its last stage does not hold a waiting triangle.
//   Stall: when rsp_ready is low the serializer holds its triplet; the pipeline keeps
//   filling empty slots and stops only when its last stage holds a waiting triangle.
//   Reset clears all valid bits and the serializer; no data is cleared.
module cotan_laplacian_triplets import clt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire clt_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output clt_rsp_type      rsp_data
);

   localparam int FRONT      = 10;
   localparam int PREP_STAGE = FRONT + ROOT_BITS;
   localparam int TOTAL      = PREP_STAGE + 1 + QUOT_BITS + 1;
   localparam int LAST       = TOTAL - 1;
   localparam int SIDE_BASE  = FRONT - 1;
   localparam int SIDE_LEN   = TOTAL - SIDE_BASE;
   localparam logic [3:0] LAST_CNT = 4'd8;

   typedef struct packed {
      logic [5:0][NUM_BITS-1:0] mag;
      logic [5:0]               neg;
      logic [5:0]               nz;
      logic                     degen;
   } clt_side_type;

   logic             adv;
   logic             emit_free;
   logic [TOTAL-1:0] vld_ff;
   logic [INDEX_BITS-1:0] ids_ff [TOTAL][3];

   // ---------------- front stages ----------------
   clt_req_type in_ff;
   logic signed [COORD_BITS:0]   e1_ff  [6];
   logic        [COORD_BITS-1:0] mag2_ff[6];
   logic                         sgn2_ff[6];
   logic        [5:0]            t2_ff;
   logic signed [29:0]           es3_ff [6];
   logic signed [59:0]           pr4_ff [15];
   logic signed [61:0]           a5_ff, b5_ff, c5_ff;
   logic signed [60:0]           cr5_ff [3];
   logic signed [NUM_BITS-1:0]   num6_ff[6];
   logic        [59:0]           cab6_ff[3];
   logic        [NUM_BITS-1:0]   mag7_ff[6];
   logic                         neg7_ff[6];
   logic        [59:0]           hh7_ff [3];
   logic        [59:0]           hl7_ff [3];
   logic        [59:0]           ll7_ff [3];
   logic        [NUM_BITS-1:0]   mag8_ff[6];
   logic                         neg8_ff[6];
   logic        [RAD_BITS-1:0]   sq8_ff [3];

   logic signed [COORD_BITS-1:0] pc [3][3];
   logic        [COORD_BITS-1:0] mag2_in[6];
   logic        [COORD_BITS-1:0] orv_in;
   logic        [5:0]            t2_in;
   logic        [28:0]           v3_in [6];
   logic        [61:0]           wide3_in [6];

   always_comb begin
      pc[0][0] = in_ff.corner0_x; pc[0][1] = in_ff.corner0_y; pc[0][2] = in_ff.corner0_z;
      pc[1][0] = in_ff.corner1_x; pc[1][1] = in_ff.corner1_y; pc[1][2] = in_ff.corner1_z;
      pc[2][0] = in_ff.corner2_x; pc[2][1] = in_ff.corner2_y; pc[2][2] = in_ff.corner2_z;
   end

   // Common scale: the largest edge component lands in [2^28, 2^29).
   always_comb begin
      orv_in = '0;
      t2_in  = '0;
      for (int i = 0; i < 6; i++) begin
         mag2_in[i] = e1_ff[i][COORD_BITS] ? COORD_BITS'(-e1_ff[i]) : COORD_BITS'(e1_ff[i]);
         orv_in     = orv_in | mag2_in[i];
      end
      for (int b = 0; b < COORD_BITS; b++) begin
         if (orv_in[b]) begin
            t2_in = 6'(b);
         end
      end
      for (int i = 0; i < 6; i++) begin
         if (t2_ff > 6'd28) begin
            wide3_in[i] = {30'b0, mag2_ff[i]} >> (t2_ff - 6'd28);
         end else begin
            wide3_in[i] = {30'b0, mag2_ff[i]} << (6'd28 - t2_ff);
         end
         v3_in[i] = wide3_in[i][28:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]     <= {pc[1][i][COORD_BITS-1], pc[1][i]} - {pc[0][i][COORD_BITS-1], pc[0][i]};
            e1_ff[3 + i] <= {pc[2][i][COORD_BITS-1], pc[2][i]} - {pc[0][i][COORD_BITS-1], pc[0][i]};
         end
         for (int i = 0; i < 6; i++) begin
            mag2_ff[i] <= mag2_in[i];
            sgn2_ff[i] <= e1_ff[i][COORD_BITS];
            es3_ff[i]  <= sgn2_ff[i] ? -$signed({1'b0, v3_in[i]}) : $signed({1'b0, v3_in[i]});
         end
         t2_ff <= t2_in;
         for (int i = 0; i < 3; i++) begin
            pr4_ff[i]     <= es3_ff[i] * es3_ff[i];
            pr4_ff[3 + i] <= es3_ff[3 + i] * es3_ff[3 + i];
            pr4_ff[6 + i] <= es3_ff[i] * es3_ff[3 + i];
         end
         pr4_ff[9]  <= es3_ff[1] * es3_ff[5];
         pr4_ff[10] <= es3_ff[2] * es3_ff[4];
         pr4_ff[11] <= es3_ff[2] * es3_ff[3];
         pr4_ff[12] <= es3_ff[0] * es3_ff[5];
         pr4_ff[13] <= es3_ff[0] * es3_ff[4];
         pr4_ff[14] <= es3_ff[1] * es3_ff[3];
         a5_ff <= 62'(pr4_ff[0]) + 62'(pr4_ff[1]) + 62'(pr4_ff[2]);
         b5_ff <= 62'(pr4_ff[3]) + 62'(pr4_ff[4]) + 62'(pr4_ff[5]);
         c5_ff <= 62'(pr4_ff[6]) + 62'(pr4_ff[7]) + 62'(pr4_ff[8]);
         cr5_ff[0] <= 61'(pr4_ff[9])  - 61'(pr4_ff[10]);
         cr5_ff[1] <= 61'(pr4_ff[11]) - 61'(pr4_ff[12]);
         cr5_ff[2] <= 61'(pr4_ff[13]) - 61'(pr4_ff[14]);
         // Off-diagonal numerators are -d, diagonal ones the sum of the other two dots.
         num6_ff[0] <= -NUM_BITS'(c5_ff);
         num6_ff[1] <= NUM_BITS'(c5_ff) - NUM_BITS'(a5_ff);
         num6_ff[2] <= NUM_BITS'(c5_ff) - NUM_BITS'(b5_ff);
         num6_ff[3] <= NUM_BITS'(a5_ff) + NUM_BITS'(b5_ff) - (NUM_BITS'(c5_ff) <<< 1);
         num6_ff[4] <= NUM_BITS'(b5_ff);
         num6_ff[5] <= NUM_BITS'(a5_ff);
         for (int i = 0; i < 3; i++) begin
            cab6_ff[i] <= cr5_ff[i][60] ? 60'(-cr5_ff[i]) : 60'(cr5_ff[i]);
            hh7_ff[i]  <= {30'b0, cab6_ff[i][59:30]} * {30'b0, cab6_ff[i][59:30]};
            hl7_ff[i]  <= {30'b0, cab6_ff[i][59:30]} * {30'b0, cab6_ff[i][29:0]};
            ll7_ff[i]  <= {30'b0, cab6_ff[i][29:0]}  * {30'b0, cab6_ff[i][29:0]};
            sq8_ff[i]  <= {hh7_ff[i], 60'b0} + {29'b0, hl7_ff[i], 31'b0} + {60'b0, ll7_ff[i]};
         end
         for (int i = 0; i < 6; i++) begin
            mag7_ff[i] <= num6_ff[i][NUM_BITS-1] ? NUM_BITS'(-num6_ff[i]) : NUM_BITS'(num6_ff[i]);
            neg7_ff[i] <= num6_ff[i][NUM_BITS-1];
            mag8_ff[i] <= mag7_ff[i];
            neg8_ff[i] <= neg7_ff[i];
         end
      end
   end

   // ---------------- square root and side line ----------------
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS+1];
   logic [REM_BITS-1:0]  srem_ff [ROOT_BITS+1];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS+1];
   clt_side_type         side_ff [SIDE_LEN];

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0]  <= sq8_ff[0] + sq8_ff[1] + sq8_ff[2];
         srem_ff[0] <= '0;
         root_ff[0] <= '0;
         side_ff[0].degen <= ~|(sq8_ff[0] | sq8_ff[1] | sq8_ff[2]);
         for (int i = 0; i < 6; i++) begin
            side_ff[0].mag[i] <= mag8_ff[i];
            side_ff[0].neg[i] <= neg8_ff[i];
            side_ff[0].nz[i]  <= |mag8_ff[i];
         end
         for (int s = 1; s < SIDE_LEN; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // One root bit per stage, two radicand bits shifted into the remainder.
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      localparam int B = ROOT_BITS - 1 - k;
      logic [REM_BITS+1:0] trem_in;
      logic [REM_BITS+1:0] trial_in;
      logic                ge_in;
      always_comb begin
         trem_in  = {srem_ff[k], rad_ff[k][2*B+1:2*B]};
         trial_in = {2'b00, root_ff[k], 2'b01};
         ge_in    = trem_in >= trial_in;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            srem_ff[k+1] <= ge_in ? REM_BITS'(trem_in - trial_in) : REM_BITS'(trem_in);
            root_ff[k+1] <= {root_ff[k][ROOT_BITS-2:0], ge_in};
            rad_ff[k+1]  <= rad_ff[k];
         end
      end
   end

   // ---------------- divider setup and lanes ----------------
   localparam int SQRT_SIDE = PREP_STAGE - 1 - SIDE_BASE;

   logic [DIV_X_BITS-1:0] x_ff [6];
   logic [DIV_D_BITS-1:0] dv_ff;
   logic [QUOT_BITS-1:0]  q_out [6];
   logic                  ovr_out [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            x_ff[i] <= DIV_X_BITS'({side_ff[SQRT_SIDE].mag[i][61:0], 16'b0})
                     + DIV_X_BITS'(root_ff[ROOT_BITS]);
         end
         dv_ff <= {root_ff[ROOT_BITS], 1'b0};
      end
   end

   for (genvar i = 0; i < 6; i++) begin : g_lane
      clt_div_lane u_div (
         .clock (clock),
         .adv   (adv),
         .x     (x_ff[i]),
         .d     (dv_ff),
         .q     (q_out[i]),
         .over  (ovr_out[i])
      );
   end

   // ---------------- valid line, index line, serializer ----------------
   logic                   emit_v_ff;
   logic [3:0]             cnt_ff;
   logic [INDEX_BITS-1:0]  em_id_ff [3];
   logic [WEIGHT_BITS-1:0] em_w_ff  [6];
   logic                   em_degen_ff;
   logic [WEIGHT_BITS-1:0] w_in [6];

   assign emit_free = !emit_v_ff || (rsp_ready && cnt_ff == LAST_CNT);
   assign adv       = emit_free || !vld_ff[LAST];
   assign req_ready = adv;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         w_in[i] = clt_weight(q_out[i], ovr_out[i], side_ff[SIDE_LEN-1].neg[i],
                              side_ff[SIDE_LEN-1].nz[i], side_ff[SIDE_LEN-1].degen);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TOTAL-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ids_ff[0][0] <= req_data.corner0_index;
         ids_ff[0][1] <= req_data.corner1_index;
         ids_ff[0][2] <= req_data.corner2_index;
         for (int s = 1; s < TOTAL; s++) begin
            ids_ff[s] <= ids_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_v_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (emit_free) begin
         emit_v_ff <= vld_ff[LAST];
         cnt_ff    <= '0;
      end else if (rsp_ready) begin
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_free) begin
         em_id_ff    <= ids_ff[LAST];
         em_w_ff     <= w_in;
         em_degen_ff <= side_ff[SIDE_LEN-1].degen;
      end
   end

   assign rsp_valid = emit_v_ff;

   always_comb begin
      rsp_data            = '0;
      rsp_data.degenerate = em_degen_ff;
      rsp_data.last_entry = (cnt_ff == LAST_CNT);
      case (cnt_ff)
         4'd0: begin
            rsp_data.row_index = em_id_ff[1]; rsp_data.column_index = em_id_ff[2];
            rsp_data.weight = em_w_ff[0];
         end
         4'd1: begin
            rsp_data.row_index = em_id_ff[2]; rsp_data.column_index = em_id_ff[1];
            rsp_data.weight = em_w_ff[0];
         end
         4'd2: begin
            rsp_data.row_index = em_id_ff[2]; rsp_data.column_index = em_id_ff[0];
            rsp_data.weight = em_w_ff[1];
         end
         4'd3: begin
            rsp_data.row_index = em_id_ff[0]; rsp_data.column_index = em_id_ff[2];
            rsp_data.weight = em_w_ff[1];
         end
         4'd4: begin
            rsp_data.row_index = em_id_ff[0]; rsp_data.column_index = em_id_ff[1];
            rsp_data.weight = em_w_ff[2];
         end
         4'd5: begin
            rsp_data.row_index = em_id_ff[1]; rsp_data.column_index = em_id_ff[0];
            rsp_data.weight = em_w_ff[2];
         end
         4'd6: begin
            rsp_data.row_index = em_id_ff[0]; rsp_data.column_index = em_id_ff[0];
            rsp_data.weight = em_w_ff[3];
         end
         4'd7: begin
            rsp_data.row_index = em_id_ff[1]; rsp_data.column_index = em_id_ff[1];
            rsp_data.weight = em_w_ff[4];
         end
         default: begin
            rsp_data.row_index = em_id_ff[2]; rsp_data.column_index = em_id_ff[2];
            rsp_data.weight = em_w_ff[5];
         end
      endcase
   end

   // ---------------- checks ----------------
   a_hold_triplet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(cnt_ff))
      else $error("triplet counter moved while the receiver stalled");

   a_degen_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.weight == '0 || rsp_data.weight == WEIGHT_MAX || rsp_data.weight == WEIGHT_MIN)
      else $error("zero-area triangle produced an unsaturated weight");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> vld_ff[LAST] && emit_v_ff)
      else $error("input stalled while the pipeline could advance");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && cnt_ff != LAST_CNT |=> rsp_valid)
      else $error("triangle dropped before its ninth triplet");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the cotangent Laplacian triplet generator.
`timescale 1ns / 1ps
module tb;
   import clt_pkg::*;

   localparam int LATENCY      = 106;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int PHASE_TRIS   = 68;
   localparam int HOLDOFF_TRIS = 200;

   typedef enum int {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_HOLDOFF
   } idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   clt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   clt_rsp_type rsp_data;

   clt_req_type   pending_tris[$];
   clt_rsp_type   expected_triplets[$];
   idle_mode_type idle_mode = IDLE_NONE;
   int            holdoff_cycles = 0;
   int            mismatches = 0;
   int            triplets_seen = 0;
   int            tris_sent = 0;
   int            degen_seen = 0;
   int            cycle_count = 0;

   cotan_laplacian_triplets DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   always #5 clock = ~clock;

   // Weight for numerator num over root n: round(num * 2^15 / n), saturated.
   function automatic logic [31:0] cot_weight(input logic signed [65:0] num,
                                              input logic [63:0] n);
      logic [65:0]  mag;
      logic [129:0] dividend;
      logic [129:0] q;
      if (n == 0) begin
         if (num > 0) return WEIGHT_MAX;
         if (num < 0) return WEIGHT_MIN;
         return '0;
      end
      mag = num < 0 ? -num : num;
      dividend = ({64'b0, mag} << 16) + n;
      q = dividend / ({66'b0, n} << 1);
      if (num >= 0) return q > 130'h7FFF_FFFF ? WEIGHT_MAX : q[31:0];
      if (q > 130'h8000_0000) q = 130'h8000_0000;
      return 32'(-q[31:0]);
   endfunction

   function automatic logic [63:0] isqrt(input logic [127:0] s);
      logic [63:0]  r;
      logic [63:0]  t;
      r = '0;
      for (int b = 61; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'b0, t} * {64'b0, t} <= s) r = t;
      end
      return r;
   endfunction

   // Compute the nine triplets for one triangle and queue them.
   task automatic predict_triplets(input clt_req_type tri_in);
      logic [13:0]         id[3];
      logic signed [65:0]  e[6];
      logic signed [65:0]  dt[3];
      logic signed [131:0] cr[3];
      logic [65:0]         m, v;
      logic [127:0]        s;
      logic [63:0]         n;
      logic signed [65:0]  aa, bb, cc;
      logic [31:0]         w;
      logic                degen;
      clt_rsp_type         r;
      int                  t, j, k;
      id[0] = tri_in.corner0_index;
      id[1] = tri_in.corner1_index;
      id[2] = tri_in.corner2_index;
      e[0] = 66'(tri_in.corner1_x) - 66'(tri_in.corner0_x);
      e[1] = 66'(tri_in.corner1_y) - 66'(tri_in.corner0_y);
      e[2] = 66'(tri_in.corner1_z) - 66'(tri_in.corner0_z);
      e[3] = 66'(tri_in.corner2_x) - 66'(tri_in.corner0_x);
      e[4] = 66'(tri_in.corner2_y) - 66'(tri_in.corner0_y);
      e[5] = 66'(tri_in.corner2_z) - 66'(tri_in.corner0_z);
      m = '0;
      for (int i = 0; i < 6; i++) begin
         v = e[i] < 0 ? -e[i] : e[i];
         if (v > m) m = v;
      end
      if (m != 0) begin
         t = 0;
         while (t < 63 && (m >> (t + 1)) != 0) t++;
         for (int i = 0; i < 6; i++) begin
            v = e[i] < 0 ? -e[i] : e[i];
            v = t > 28 ? v >> (t - 28) : v << (28 - t);
            e[i] = e[i] < 0 ? -$signed(v) : $signed(v);
         end
      end
      aa = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
      bb = e[3] * e[3] + e[4] * e[4] + e[5] * e[5];
      cc = e[0] * e[3] + e[1] * e[4] + e[2] * e[5];
      dt[0] = cc;
      dt[1] = aa - cc;
      dt[2] = bb - cc;
      cr[0] = 132'(e[1]) * 132'(e[5]) - 132'(e[2]) * 132'(e[4]);
      cr[1] = 132'(e[2]) * 132'(e[3]) - 132'(e[0]) * 132'(e[5]);
      cr[2] = 132'(e[0]) * 132'(e[4]) - 132'(e[1]) * 132'(e[3]);
      s = '0;
      for (int i = 0; i < 3; i++) s += 128'(cr[i] * cr[i]);
      degen = (s == 0);
      n = degen ? '0 : isqrt(s);
      if (degen) degen_seen++;
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         w = cot_weight(-dt[i], n);
         r = '{row_index: id[j], column_index: id[k], weight: w,
               degenerate: degen, last_entry: 1'b0};
         expected_triplets = {expected_triplets, r};
         r.row_index = id[k];
         r.column_index = id[j];
         expected_triplets = {expected_triplets, r};
      end
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         r = '{row_index: id[i], column_index: id[i],
               weight: cot_weight(dt[j] + dt[k], n),
               degenerate: degen, last_entry: i == 2};
         expected_triplets = {expected_triplets, r};
      end
   endtask

   // Random coordinate: mix of small local meshes, full-range and extreme values.
   function automatic logic [31:0] rand_coord(input logic [31:0] base);
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2:       return base;
         3:       return base + $urandom_range(0, 3) - 1;
         default: return base + ($signed($urandom) >>> $urandom_range(8, 24));
      endcase
   endfunction

   function automatic clt_req_type rand_tri();
      clt_req_type tr;
      logic [31:0] bx, by, bz;
      bx = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom) >>> 8;
      by = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom) >>> 8;
      bz = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom) >>> 8;
      tr.corner0_index = INDEX_BITS'($urandom);
      tr.corner1_index = INDEX_BITS'($urandom);
      tr.corner2_index = INDEX_BITS'($urandom);
      tr.corner0_x = rand_coord(bx);
      tr.corner0_y = rand_coord(by);
      tr.corner0_z = rand_coord(bz);
      tr.corner1_x = rand_coord(bx);
      tr.corner1_y = rand_coord(by);
      tr.corner1_z = rand_coord(bz);
      tr.corner2_x = rand_coord(bx);
      tr.corner2_y = rand_coord(by);
      tr.corner2_z = rand_coord(bz);
      // Occasionally collapse onto a line or a point for zero area.
      if ($urandom_range(0, 19) == 0) begin
         tr.corner2_x = tr.corner1_x;
         tr.corner2_y = tr.corner1_y;
         tr.corner2_z = tr.corner1_z;
      end
      return tr;
   endfunction

   function automatic clt_req_type make_tri(
      input logic [13:0] i0, input logic [31:0] x0, y0, z0,
      input logic [13:0] i1, input logic [31:0] x1, y1, z1,
      input logic [13:0] i2, input logic [31:0] x2, y2, z2);
      return '{i0, x0, y0, z0, i1, x1, y1, z1, i2, x2, y2, z2};
   endfunction

   task automatic queue_tri(input clt_req_type tr);
      pending_tris = {pending_tris, tr};
   endtask

   task automatic wait_drained();
      while (pending_tris.size() != 0 || req_valid || expected_triplets.size() != 0)
         @(posedge clock);
   endtask

   // Driver: offer the next pending triangle, idling as the phase asks.
   always @(posedge clock) begin
      logic idle;
      idle = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 76) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 25);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) tris_sent++;
         if (pending_tris.size() != 0 && !idle) begin
            req_data  <= pending_tris[0];
            req_valid <= 1'b1;
            predict_triplets(pending_tris.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver ready, with random stalls and a long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_ready <= $urandom_range(0, 99) >= 76;
            IDLE_BOTH:     rsp_ready <= $urandom_range(0, 99) >= 25;
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   // Monitor: check each transfer against the oldest expected triplet.
   always @(posedge clock) begin
      clt_rsp_type exp_t;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         triplets_seen++;
         if (expected_triplets.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected triplet %p", rsp_data);
         end else begin
            exp_t = expected_triplets.pop_front();
            if (rsp_data !== exp_t) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", exp_t, rsp_data);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("cotan_laplacian_triplets regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: right triangle, extremes, zero area, coincident corners.
      queue_tri(make_tri(0, 0, 0, 0, 1, 32'h10000, 0, 0,
                         2, 0, 32'h10000, 0));
      queue_tri(make_tri(14'h3FFF, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 14'h2AAA, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 14'h1555,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      queue_tri(make_tri(5, 7, 7, 7, 6, 7, 7, 7, 7, 7, 7, 7));
      queue_tri(make_tri(1, 0, 0, 0, 2, 32'h10000, 0, 0,
                         3, 32'h20000, 0, 0));
      queue_tri(make_tri(9, 0, 0, 0, 10, 32'h7FFF_FFFF, 0, 0,
                         11, 32'h3FFF_FFFF, 1, 0));
      queue_tri(make_tri(3, 0, 0, 0, 3, 1, 0, 0, 3, 0, 1, 0));
      queue_tri(make_tri(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0,
                         32'h8000_0000, 14'h3FFF, 0,
                         32'h7FFF_FFFF, 32'hFFFF_FFFF));
      queue_tri(make_tri(12, 0, 0, 0, 13, 32'h10000, 0, 0,
                         14, 32'h8000, 1, 0));
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         idle_mode = idle_mode_type'(ph);
         // The hold-off phase offers more triangles than the pipeline can hold.
         for (int i = 0; i < (idle_mode == IDLE_HOLDOFF ? HOLDOFF_TRIS : PHASE_TRIS); i++)
            queue_tri(rand_tri());
         // Stall the receiver long enough to fill the pipeline.
         if (idle_mode == IDLE_HOLDOFF) holdoff_cycles = 2000;
         wait_drained();
      end
      idle_mode = IDLE_NONE;
      repeat (LATENCY + 20) @(posedge clock);

      $display("sent %0d triangles (%0d zero-area), checked %0d triplets",
               tris_sent, degen_seen, triplets_seen);
      $display("idle phases: none, sender, receiver, both, long receiver hold-off");
      if (mismatches == 0 && expected_triplets.size() == 0) begin
         $display("cotan_laplacian_triplets regression: pass");
      end else begin
         $display("%0d mismatches, %0d triplets missing", mismatches,
                  expected_triplets.size());
         $display("cotan_laplacian_triplets regression: fail");
      end
      $finish;
   end
endmodule
